[hdl/psc_pkg.sv]
// ----------------------------------------------------------------------------
// PID speed controller package
// Sequencer states, register indexes, status codes and widths used by the controller.
// ----------------------------------------------------------------------------
package psc_pkg;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_MUL_I,
        ST_DIV_I,
        ST_CLAMP,
        ST_MUL_D,
        ST_DIV_D,
        ST_MUL_P,
        ST_MUL_IG,
        ST_MUL_DG,
        ST_FINAL,
        ST_OUT
    } psc_state_t;

    localparam logic [2:0] REG_SETPOINT  = 3'd0;
    localparam logic [2:0] REG_GAIN_P    = 3'd1;
    localparam logic [2:0] REG_GAIN_I    = 3'd2;
    localparam logic [2:0] REG_GAIN_D    = 3'd3;
    localparam logic [2:0] REG_INT_LIMIT = 3'd4;

    localparam logic [1:0] STAT_FIRST  = 2'd0;
    localparam logic [1:0] STAT_UPDATE = 2'd1;
    localparam logic [1:0] STAT_REPEAT = 2'd2;

    localparam int ACC_W = 72;
    localparam int MP_W  = 40;
    localparam int NUM_W = 64;

endpackage

[hdl/pid_speed_controller.sv]
// First and repeated ticks skip the arithmetic and go straight to the output state.
// A normal tick runs five bit-serial shift-add products (one multiplier bit per
// cycle, ending early once the multiplier is spent) and two 64-step restoring
// divisions (one quotient bit per cycle).
// No new word is taken while a tick is in progress; the next word is taken once the result is queued.
// Reset clears the controller state, gains to zero and the integral limit to maximum.
// ----------------------------------------------------------------------------
// PID speed controller
// Fixed-point PID with anti-windup, serial multiply and divide sequencer.
// ----------------------------------------------------------------------------
module pid_speed_controller
    import psc_pkg::*;
#(
    parameter int OUT_MAX         = 255,
    parameter int SPEED_FRAC_BITS = 8
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_we,
    input  logic [2:0]  cfg_index,
    input  logic [31:0] cfg_data,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [55:0] s_tdata,   // measured_speed[23:0], now_ms[55:24]
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [15:0] m_tdata    // drive[8:0], status[10:9], zero[15:11]
);

    localparam int PROD_SHIFT = SPEED_FRAC_BITS + 16;
    localparam logic signed [24:0] JUMP_LIMIT = 25'(10 << SPEED_FRAC_BITS);
    localparam logic [ACC_W-1:0] LOW_MASK = (ACC_W'(1) << PROD_SHIFT) - ACC_W'(1);
    localparam logic signed [ACC_W-1:0] OMAX = ACC_W'(OUT_MAX);

    psc_state_t state_reg, state_next;

    logic signed [23:0] setpoint_reg;
    logic signed [31:0] gain_p_reg, gain_i_reg, gain_d_reg;
    logic [22:0]        limit_reg;
    logic signed [23:0] integ_reg;
    logic signed [24:0] prev_err_reg;
    logic signed [8:0]  prev_drive_reg;
    logic [31:0]        prev_time_reg;
    logic               first_reg;

    logic signed [24:0] err_reg;
    logic [31:0]        ms_reg;
    logic [31:0]        now_reg;
    logic signed [23:0] new_integ_reg;
    logic [39:0]        deriv_reg;
    logic               deriv_neg_reg;

    logic [ACC_W-1:0]        mc_reg;
    logic [MP_W-1:0]         mp_reg;
    logic [ACC_W-1:0]        prod_reg;
    logic signed [ACC_W-1:0] acc_reg;
    logic [NUM_W-1:0]        num_reg;
    logic [32:0]             rem_reg;
    logic [31:0]             den_reg;
    logic [5:0]              cnt_reg;

    logic signed [8:0] res_drive_reg;
    logic [1:0]        res_stat_reg;
    logic              out_valid_reg;
    logic [8:0]        out_drive_reg;
    logic [1:0]        out_stat_reg;

    logic signed [24:0] meas_x, sp_x, err_in, sp_diff, sp_new;
    logic [31:0]        ms_in;
    logic [24:0]        err_mag;
    logic signed [25:0] diff;
    logic [25:0]        diff_mag;
    logic [32:0]        kp_mag, ki_mag, kd_mag;
    logic [32:0]        rem_sh;
    logic               rem_ge;
    logic signed [48:0] q_s, isum, lim_s;
    logic signed [ACC_W-1:0] prod_s, fl, f;
    logic signed [8:0]  sat_drive;
    logic               mul_done, out_free;

    assign meas_x  = 25'(signed'(s_tdata[23:0]));
    assign sp_x    = 25'(setpoint_reg);
    assign err_in  = sp_x - meas_x;
    assign ms_in   = s_tdata[55:24] - prev_time_reg;
    assign sp_new  = 25'(signed'(cfg_data[23:0]));
    assign sp_diff = sp_new - sp_x;

    assign err_mag   = err_reg[24] ? 25'(-err_reg) : 25'(err_reg);
    assign diff      = 26'(err_reg) - 26'(prev_err_reg);
    assign diff_mag  = diff[25] ? 26'(-diff) : 26'(diff);
    assign kp_mag    = gain_p_reg[31] ? 33'(-33'(gain_p_reg)) : 33'(gain_p_reg);
    assign ki_mag    = gain_i_reg[31] ? 33'(-33'(gain_i_reg)) : 33'(gain_i_reg);
    assign kd_mag    = gain_d_reg[31] ? 33'(-33'(gain_d_reg)) : 33'(gain_d_reg);

    assign rem_sh = {rem_reg[31:0], num_reg[NUM_W-1]};
    assign rem_ge = rem_sh >= {1'b0, den_reg};

    assign mul_done = (mp_reg == '0);
    assign out_free = !out_valid_reg || m_tready;

    assign q_s   = err_reg[24] ? -49'(num_reg[47:0]) : 49'(num_reg[47:0]);
    assign isum  = 49'(integ_reg) + q_s;
    assign lim_s = 49'(limit_reg);

    always_comb
    begin
        prod_s = signed'(prod_reg);
        unique case (state_reg)
            ST_MUL_P:  if (err_reg[24] != gain_p_reg[31]) prod_s = -signed'(prod_reg);
            ST_MUL_IG: if (new_integ_reg[23] != gain_i_reg[31]) prod_s = -signed'(prod_reg);
            ST_MUL_DG: if (deriv_neg_reg != gain_d_reg[31]) prod_s = -signed'(prod_reg);
            default:   prod_s = signed'(prod_reg);
        endcase
    end

    assign fl = acc_reg >>> PROD_SHIFT;
    assign f  = fl + ACC_W'((acc_reg < 0) && ((acc_reg & LOW_MASK) != '0));

    always_comb
    begin
        if (f > OMAX)
            sat_drive = OMAX[8:0];
        else if (f < -OMAX)
            sat_drive = 9'(-OMAX);
        else
            sat_drive = f[8:0];
    end

    assign s_tready = (state_reg == ST_IDLE);
    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {5'b0, out_stat_reg, out_drive_reg};

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
                if (s_tvalid)
                begin
                    if (first_reg || ms_in == '0)
                        state_next = ST_OUT;
                    else
                        state_next = ST_MUL_I;
                end
            ST_MUL_I:  if (mul_done) state_next = ST_DIV_I;
            ST_DIV_I:  if (cnt_reg == '0) state_next = ST_CLAMP;
            ST_CLAMP:  state_next = ST_MUL_D;
            ST_MUL_D:  if (mul_done) state_next = ST_DIV_D;
            ST_DIV_D:  if (cnt_reg == '0) state_next = ST_MUL_P;
            ST_MUL_P:  if (mul_done) state_next = ST_MUL_IG;
            ST_MUL_IG: if (mul_done) state_next = ST_MUL_DG;
            ST_MUL_DG: if (mul_done) state_next = ST_FINAL;
            ST_FINAL:  state_next = ST_OUT;
            ST_OUT:    if (out_free) state_next = ST_IDLE;
            default:   state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_IDLE;
            setpoint_reg   <= '0;
            gain_p_reg     <= '0;
            gain_i_reg     <= '0;
            gain_d_reg     <= '0;
            limit_reg      <= '1;
            integ_reg      <= '0;
            prev_err_reg   <= '0;
            prev_drive_reg <= '0;
            prev_time_reg  <= '0;
            first_reg      <= 1'b1;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (state_reg == ST_OUT && out_free)
                out_valid_reg <= 1'b1;
            else if (m_tready)
                out_valid_reg <= 1'b0;
            if (cfg_we)
            begin
                unique case (cfg_index)
                    REG_SETPOINT:
                    begin
                        if (sp_diff > JUMP_LIMIT || sp_diff < -JUMP_LIMIT)
                        begin
                            integ_reg      <= '0;
                            prev_err_reg   <= '0;
                            prev_drive_reg <= '0;
                            prev_time_reg  <= '0;
                            first_reg      <= 1'b1;
                        end
                        setpoint_reg <= cfg_data[23:0];
                    end
                    REG_GAIN_P:    gain_p_reg <= cfg_data;
                    REG_GAIN_I:    gain_i_reg <= cfg_data;
                    REG_GAIN_D:    gain_d_reg <= cfg_data;
                    REG_INT_LIMIT: limit_reg  <= cfg_data[22:0];
                    default:       ;
                endcase
            end
            unique case (state_reg)
                ST_IDLE:
                    if (s_tvalid && first_reg)
                    begin
                        prev_time_reg <= s_tdata[55:24];
                        prev_err_reg  <= err_in;
                        first_reg     <= 1'b0;
                    end
                ST_FINAL:
                begin
                    integ_reg      <= new_integ_reg;
                    prev_err_reg   <= err_reg;
                    prev_time_reg  <= now_reg;
                    prev_drive_reg <= sat_drive;
                end
                default: ;
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        unique case (state_reg)
            ST_IDLE:
                if (s_tvalid)
                begin
                    err_reg  <= err_in;
                    ms_reg   <= ms_in;
                    now_reg  <= s_tdata[55:24];
                    mc_reg   <= ACC_W'(err_in[24] ? 25'(-err_in) : 25'(err_in));
                    mp_reg   <= MP_W'(ms_in);
                    prod_reg <= '0;
                    if (first_reg)
                    begin
                        res_drive_reg <= '0;
                        res_stat_reg  <= STAT_FIRST;
                    end
                    else if (ms_in == '0)
                    begin
                        res_drive_reg <= prev_drive_reg;
                        res_stat_reg  <= STAT_REPEAT;
                    end
                end
            ST_MUL_I, ST_MUL_D, ST_MUL_P, ST_MUL_IG, ST_MUL_DG:
                if (!mul_done)
                begin
                    if (mp_reg[0])
                        prod_reg <= prod_reg + mc_reg;
                    mc_reg <= mc_reg << 1;
                    mp_reg <= mp_reg >> 1;
                end
                else
                begin
                    unique case (state_reg)
                        ST_MUL_I:
                        begin
                            num_reg <= prod_reg[NUM_W-1:0];
                            den_reg <= 32'd1000;
                            rem_reg <= '0;
                            cnt_reg <= '1;
                        end
                        ST_MUL_D:
                        begin
                            num_reg <= prod_reg[NUM_W-1:0];
                            den_reg <= ms_reg;
                            rem_reg <= '0;
                            cnt_reg <= '1;
                        end
                        ST_MUL_P:
                        begin
                            acc_reg <= acc_reg + prod_s;
                            mc_reg  <= ACC_W'(ki_mag);
                            mp_reg  <= MP_W'(new_integ_reg[23] ? 24'(-new_integ_reg)
                                                               : 24'(new_integ_reg));
                        end
                        ST_MUL_IG:
                        begin
                            acc_reg <= acc_reg + prod_s;
                            mc_reg  <= ACC_W'(kd_mag);
                            mp_reg  <= deriv_reg;
                        end
                        default:
                            acc_reg <= acc_reg + prod_s;
                    endcase
                    prod_reg <= '0;
                end
            ST_DIV_I, ST_DIV_D:
            begin
                rem_reg <= rem_ge ? rem_sh - {1'b0, den_reg} : rem_sh;
                num_reg <= {num_reg[NUM_W-2:0], rem_ge};
                cnt_reg <= cnt_reg - 6'd1;
                if (cnt_reg == '0 && state_reg == ST_DIV_D)
                begin
                    deriv_reg     <= MP_W'({num_reg[NUM_W-2:0], rem_ge});
                    deriv_neg_reg <= diff[25];
                    acc_reg       <= '0;
                    mc_reg        <= ACC_W'(kp_mag);
                    mp_reg        <= MP_W'(err_mag);
                    prod_reg      <= '0;
                end
            end
            ST_CLAMP:
            begin
                if (isum > lim_s)
                    new_integ_reg <= 24'(limit_reg);
                else if (isum < -lim_s)
                    new_integ_reg <= -24'(limit_reg);
                else
                    new_integ_reg <= isum[23:0];
                mc_reg   <= ACC_W'(diff_mag);
                mp_reg   <= MP_W'(1000);
                prod_reg <= '0;
            end
            ST_FINAL:
            begin
                res_drive_reg <= sat_drive;
                res_stat_reg  <= STAT_UPDATE;
            end
            ST_OUT:
                if (out_free)
                begin
                    out_drive_reg <= res_drive_reg;
                    out_stat_reg  <= res_stat_reg;
                end
            default: ;
        endcase
    end

endmodule

[sim/testbench.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// PID speed controller testbench
// Drives control ticks through the stream ports under varied gains, limits,
// setpoints and backpressure. A scoreboard class recomputes each drive value
// and status in fixed point and checks every result word in order.
// ----------------------------------------------------------------------------
module testbench;
    import psc_pkg::*;

    localparam int  OUT_MAX    = 255;
    localparam int  FRAC       = 8;
    localparam int  DRAIN_WAIT = 16;
    localparam longint LIMIT   = 3000000;

    typedef struct {
        logic [8:0] drive;
        logic [1:0] status;
    } tick_result_t;

    class pid_scoreboard;
        longint setpoint, kp, ki, kd, int_limit;
        longint integ_sum, last_err, last_drive;
        logic [31:0] last_ms;
        bit first;
        tick_result_t pending_q[$];
        int errors, checked;

        function new();
            setpoint = 0; kp = 0; ki = 0; kd = 0; int_limit = 8388607;
            errors = 0; checked = 0;
            clear_loop();
        endfunction

        function void clear_loop();
            integ_sum = 0; last_err = 0; last_drive = 0; last_ms = 0; first = 1;
        endfunction

        function void write_reg(logic [2:0] idx, logic [31:0] val);
            longint nv, diff;
            case (idx)
                REG_SETPOINT: begin
                    nv = longint'($signed(val[23:0]));
                    diff = nv - setpoint;
                    if (diff < 0) diff = -diff;
                    if (diff > (longint'(10) << FRAC)) clear_loop();
                    setpoint = nv;
                end
                REG_GAIN_P:    kp = longint'($signed(val));
                REG_GAIN_I:    ki = longint'($signed(val));
                REG_GAIN_D:    kd = longint'($signed(val));
                REG_INT_LIMIT: int_limit = longint'({41'd0, val[22:0]});
                default: ;
            endcase
        endfunction

        function longint floor_div(longint x, longint d, output longint r);
            longint q;
            q = x / d;
            r = x % d;
            if (r < 0)
            begin
                q = q - 1;
                r = r + d;
            end
            return q;
        endfunction

        function void note_tick(logic [23:0] spd, logic [31:0] now);
            longint err, msv, integ, deriv, dh, dl, acc, al, f, scale;
            logic [31:0] ms;
            tick_result_t r;
            scale = longint'(1) << (FRAC + 16);
            err = setpoint - longint'($signed(spd));
            if (first)
            begin
                last_ms = now;
                last_err = err;
                first = 0;
                r.drive = '0;
                r.status = STAT_FIRST;
            end
            else
            begin
                ms = now - last_ms;
                if (ms == 0)
                begin
                    r.drive = last_drive[8:0];
                    r.status = STAT_REPEAT;
                end
                else
                begin
                    msv = longint'({32'd0, ms});
                    integ = integ_sum + (err * msv) / 1000;
                    if (integ > int_limit) integ = int_limit;
                    else if (integ < -int_limit) integ = -int_limit;
                    integ_sum = integ;
                    deriv = ((err - last_err) * 1000) / msv;
                    dh = floor_div(deriv, scale, dl);
                    acc = kp * err + ki * integ + kd * dl;
                    f = floor_div(acc, scale, al) + kd * dh;
                    if (f < 0 && al != 0) f = f + 1;
                    if (f > OUT_MAX) f = OUT_MAX;
                    else if (f < -OUT_MAX) f = -OUT_MAX;
                    last_err = err;
                    last_drive = f;
                    last_ms = now;
                    r.drive = f[8:0];
                    r.status = STAT_UPDATE;
                end
            end
            pending_q.push_back(r);
        endfunction

        task report(string what, logic [15:0] got, logic [15:0] want);
            errors++;
            $display("MISMATCH %s: got %0h expected %0h (result %0d)", what, got, want,
                     checked);
        endtask

        task check_word(logic [15:0] word);
            tick_result_t e;
            if (pending_q.size() == 0)
                report("unexpected word", word, 16'h0);
            else
            begin
                e = pending_q.pop_front();
                if (word[8:0] !== e.drive) report("drive", word[8:0], e.drive);
                if (word[10:9] !== e.status) report("status", word[10:9], e.status);
                if (word[15:11] !== 5'd0) report("pad", word[15:11], 16'h0);
            end
            checked++;
        endtask
    endclass

    logic        clk = 0;
    logic        rst_n = 0;
    logic        cfg_we = 0;
    logic [2:0]  cfg_index = '0;
    logic [31:0] cfg_data = '0;
    logic        s_tvalid = 0;
    logic        s_tready;
    logic [55:0] s_tdata = '0;
    logic        m_tvalid;
    logic        m_tready = 0;
    logic [15:0] m_tdata;

    pid_scoreboard sb = new();
    int send_idle_pct = 0;
    int recv_stall_pct = 0;
    int hold_cycles = 0;
    longint cycles = 0;
    int sent = 0;
    logic [31:0] stim_ms = 0;

    pid_speed_controller #(.OUT_MAX(OUT_MAX), .SPEED_FRAC_BITS(FRAC)) dut (.*);

    always #5 clk = ~clk;

    always @(posedge clk)
    begin
        cycles++;
        if (cycles > LIMIT)
        begin
            $display("timeout after %0d cycles", cycles);
            $display("testbench failed");
            $finish;
        end
    end

    always @(negedge clk)
    begin
        if (hold_cycles > 0)
        begin
            hold_cycles <= hold_cycles - 1;
            m_tready <= 0;
        end
        else
            m_tready <= ($urandom_range(99) >= recv_stall_pct);
    end

    always @(posedge clk)
        if (m_tvalid && m_tready)
            sb.check_word(m_tdata);

    task write_reg(logic [2:0] idx, logic [31:0] val);
        @(negedge clk);
        cfg_we <= 1;
        cfg_index <= idx;
        cfg_data <= val;
        sb.write_reg(idx, val);
        @(negedge clk);
        cfg_we <= 0;
    endtask

    // called at a falling edge; returns at the falling edge after acceptance
    task send_tick(logic [23:0] spd, logic [31:0] now);
        bit done;
        done = 0;
        while (send_idle_pct > 0 && $urandom_range(99) < send_idle_pct)
        begin
            s_tvalid <= 0;
            @(negedge clk);
        end
        s_tvalid <= 1;
        s_tdata <= {now, spd};
        while (!done)
        begin
            @(posedge clk);
            if (s_tready)
            begin
                sb.note_tick(spd, now);
                done = 1;
                sent++;
            end
            @(negedge clk);
        end
    endtask

    task drain();
        s_tvalid <= 0;
        while (sb.pending_q.size() != 0) @(negedge clk);
        repeat (DRAIN_WAIT) @(negedge clk);
    endtask

    function logic [31:0] pick_gain();
        case ($urandom_range(5))
            0: return 32'h8000_0000;
            1: return 32'h7FFF_FFFF;
            2: return $urandom();
            default: return $urandom_range(0, 1 << 18) - (1 << 17);
        endcase
    endfunction

    task random_tick();
        logic [23:0] spd;
        int r;
        r = $urandom_range(99);
        if (r < 8) ;
        else if (r < 16) stim_ms = $urandom();
        else if (r < 20) stim_ms = 32'hFFFF_FFF0 + $urandom_range(15);
        else stim_ms = stim_ms + $urandom_range(1, 200);
        if ($urandom_range(99) < 15) spd = $urandom();
        else spd = sb.setpoint[23:0] + 24'($urandom_range(0, 25600)) - 24'd12800;
        send_tick(spd, stim_ms);
    endtask

    initial
    begin
        int p, n;
        repeat (6) @(negedge clk);
        rst_n = 1;
        @(negedge clk);

        write_reg(REG_GAIN_P, 32'h0001_0000);
        write_reg(REG_GAIN_I, 32'h0000_4000);
        write_reg(REG_GAIN_D, 32'h0000_0400);
        write_reg(REG_INT_LIMIT, 32'h0000_2000);
        write_reg(REG_SETPOINT, 32'h0000_6400);
        send_tick(24'h006000, 32'd0);
        send_tick(24'h006000, 32'd0);
        send_tick(24'h007FFF, 32'd10);
        send_tick(24'h800000, 32'd11);
        send_tick(24'h7FFFFF, 32'd12);
        send_tick(24'h000000, 32'd1012);
        send_tick(24'hFFFFFF, 32'hFFFF_FFFF);
        send_tick(24'hFFFFFF, 32'hFFFF_FFFF);
        send_tick(24'h006400, 32'd5);
        send_tick(24'h123456, 32'hAAAA_AAAA);
        send_tick(24'hEDCBA9, 32'h5555_5555);
        drain();
        write_reg(REG_SETPOINT, 32'h0000_6E00);
        send_tick(24'h006000, 32'd100);
        drain();
        write_reg(REG_SETPOINT, 32'h0000_6E01);
        send_tick(24'h006000, 32'd100);
        send_tick(24'h006000, 32'd101);
        drain();
        write_reg(REG_INT_LIMIT, 32'h0000_0000);
        write_reg(3'd7, 32'hFFFF_FFFF);
        send_tick(24'h000000, 32'd300);
        send_tick(24'h800000, 32'd2000);
        drain();
        write_reg(REG_INT_LIMIT, 32'hFFFF_FFFF);
        send_tick(24'h7FFFFF, 32'd2500);
        send_tick(24'h800000, 32'd2501);

        for (p = 0; p < 8; p++)
        begin
            drain();
            send_idle_pct = (p % 4 == 1) ? 55 : (p % 4 == 3) ? 38 : 0;
            recv_stall_pct = (p % 4 == 2) ? 55 : (p % 4 == 3) ? 38 : 0;
            case (p)
                0: write_reg(REG_SETPOINT, 32'h0080_0000);
                1: write_reg(REG_SETPOINT, 32'h007F_FFFF);
                default: write_reg(REG_SETPOINT, $urandom_range(0, 200000) - 100000);
            endcase
            write_reg(REG_GAIN_P, pick_gain());
            write_reg(REG_GAIN_I, pick_gain());
            write_reg(REG_GAIN_D, pick_gain());
            case ($urandom_range(3))
                0: write_reg(REG_INT_LIMIT, 32'd0);
                1: write_reg(REG_INT_LIMIT, 32'h007F_FFFF);
                default: write_reg(REG_INT_LIMIT, $urandom());
            endcase
            for (n = 0; n < 48; n++)
            begin
                if (p == 2 && n == 5) hold_cycles = 3000;
                if (p == 5 && n == 24) drain();
                random_tick();
            end
        end
        drain();
        $display("sent %0d ticks over 8 gain/limit/setpoint phases, checked %0d results",
                 sent, sb.checked);
        if (sb.errors == 0 && sb.pending_q.size() == 0)
            $display("testbench passed");
        else
            $display("testbench failed");
        $finish;
    end
endmodule

[sim.f]
hdl/psc_pkg.sv
hdl/pid_speed_controller.sv
sim/testbench.sv
